@@ design/odtt_pkg.sv @@
package odtt_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int CMD_W   = 2;
   localparam int ID_W    = 32;
   localparam int DELAY_W = 32;
   localparam int DL_W    = 48;
   localparam int SLEEP_W = DL_W + 1;
   localparam int PEND_W  = 5;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_CANCEL = 2'd1;
   localparam cmd_type CMD_TICK   = 2'd2;
   localparam cmd_type CMD_FIRE   = 2'd3;

   localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [DL_W-1:0] deadline;
   } entry_type;

endpackage

@@ design/ordered_deadline_timer_table.sv @@
// Timer table of CAPACITY entries (id, absolute deadline) held in a synchronous RAM, with a
// saturating millisecond clock and a wrapping id counter. Commands: add, cancel, tick, fire
// earliest due. Each request gives exactly one response. Every command sweeps the whole RAM,
// one entry per cycle, to find a matching entry, the first free slot and the two earliest
// deadlines, then writes back in the apply state; req_stall stays high from the transfer
// through the sweep, drain, apply and output states. The response sits in an output register,
// so a stalled response delays only the hand-over of the next one. No clearing pass is
// needed after reset.
module ordered_deadline_timer_table #(
   parameter int CAPACITY = odtt_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [odtt_pkg::CMD_W-1:0]    req_command,
   input  logic [odtt_pkg::DELAY_W-1:0]  req_delay_ms,
   input  logic [odtt_pkg::ID_W-1:0]     req_cancel_id,
   input  logic [odtt_pkg::DL_W-1:0]     req_cancel_deadline,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [odtt_pkg::ID_W-1:0]     rsp_timer_id,
   output logic [odtt_pkg::DL_W-1:0]     rsp_timer_deadline,
   output logic signed [odtt_pkg::SLEEP_W-1:0] rsp_sleep_ms,
   output logic [odtt_pkg::PEND_W-1:0]   rsp_pending
);
   import odtt_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = ($clog2(CAPACITY + 1) > PEND_W) ? $clog2(CAPACITY + 1) : PEND_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_APPLY = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   entry_type entry_mem [CAPACITY];

   logic [2:0]          state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   entry_type           key_ff, key_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                cmp_act_ff, cmp_act_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   entry_type           rd_ff;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DL_W-1:0]     now_ff, now_in;
   logic [ID_W-1:0]     next_id_ff, next_id_in;
   logic                match_ff, match_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                best_v_ff, best_v_in;
   entry_type           best_ff, best_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic                sec_v_ff, sec_v_in;
   logic [DL_W-1:0]     sec_dl_ff, sec_dl_in;
   logic                ok_ff, ok_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [DL_W-1:0]     rdl_ff, rdl_in;
   logic                fe_v_ff, fe_v_in;
   logic [DL_W-1:0]     fe_dl_ff, fe_dl_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [DL_W-1:0]     rsp_dl_ff, rsp_dl_in;
   logic [SLEEP_W-1:0]  rsp_sleep_ff, rsp_sleep_in;
   logic [PEND_W-1:0]   rsp_pend_ff, rsp_pend_in;

   logic               req_take;
   logic               mem_we;
   logic [DL_W:0]      add_sum;
   logic [DL_W-1:0]    add_dl;
   logic               cur_v;
   logic               beats_best;
   logic               add_ok;
   logic               fire_ok;
   logic [SLEEP_W-1:0] diff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign add_sum = {1'b0, now_ff} + (DL_W + 1)'(req_delay_ms);
   assign add_dl  = add_sum[DL_W] ? DL_MAX : add_sum[DL_W-1:0];

   assign cur_v      = cmp_act_ff && valid_ff[cmp_idx_ff];
   assign beats_best = !best_v_ff || (rd_ff.deadline < best_ff.deadline) ||
                       ((rd_ff.deadline == best_ff.deadline) && (rd_ff.id < best_ff.id));

   assign add_ok  = !match_ff && free_ff;
   assign fire_ok = best_v_ff && (best_ff.deadline <= now_ff);
   assign mem_we  = (state_ff == ST_APPLY) && (cmd_ff == CMD_ADD) && add_ok;

   assign diff = {1'b0, fe_dl_ff} - {1'b0, now_ff};

   // RAM: written only in the apply cycle, read every cycle but used only during the sweep
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[free_idx_ff] <= key_ff;
      end
      rd_ff <= entry_mem[scan_ff];
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      scan_in      = scan_ff;
      cmp_act_in   = (state_ff == ST_SCAN);
      cmp_idx_in   = scan_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      next_id_in   = next_id_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      best_v_in    = best_v_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      sec_v_in     = sec_v_ff;
      sec_dl_in    = sec_dl_ff;
      ok_in        = ok_ff;
      rid_in       = rid_ff;
      rdl_in       = rdl_ff;
      fe_v_in      = fe_v_ff;
      fe_dl_in     = fe_dl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_sleep_in = rsp_sleep_ff;
      rsp_pend_in  = rsp_pend_ff;

      // sweep compare, one entry per cycle
      if (cur_v) begin
         if (rd_ff == key_ff) begin
            match_in     = 1'b1;
            match_idx_in = cmp_idx_ff;
         end
         if (beats_best) begin
            best_v_in   = 1'b1;
            best_in     = rd_ff;
            best_idx_in = cmp_idx_ff;
            sec_v_in    = best_v_ff;
            sec_dl_in   = best_ff.deadline;
         end else if (!sec_v_ff || (rd_ff.deadline < sec_dl_ff)) begin
            sec_v_in  = 1'b1;
            sec_dl_in = rd_ff.deadline;
         end
      end else if (cmp_act_ff && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = cmp_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in    = req_command;
               key_in    = (req_command == CMD_ADD)
                           ? entry_type'{id: next_id_ff, deadline: add_dl}
                           : entry_type'{id: req_cancel_id, deadline: req_cancel_deadline};
               scan_in   = '0;
               match_in  = 1'b0;
               free_in   = 1'b0;
               best_v_in = 1'b0;
               sec_v_in  = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ok_in    = 1'b0;
            rid_in   = '0;
            rdl_in   = '0;
            fe_v_in  = best_v_ff;
            fe_dl_in = best_ff.deadline;
            case (cmd_ff)
               CMD_ADD: begin
                  rid_in     = key_ff.id;
                  rdl_in     = key_ff.deadline;
                  next_id_in = next_id_ff + ID_W'(1);
                  if (add_ok) begin
                     ok_in                 = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + CNT_W'(1);
                     fe_v_in               = 1'b1;
                     if (!best_v_ff || (key_ff.deadline < best_ff.deadline)) begin
                        fe_dl_in = key_ff.deadline;
                     end
                  end
               end
               CMD_CANCEL: begin
                  if (match_ff) begin
                     ok_in                  = 1'b1;
                     valid_in[match_idx_ff] = 1'b0;
                     count_in               = count_ff - CNT_W'(1);
                     if (match_idx_ff == best_idx_ff) begin
                        fe_v_in  = sec_v_ff;
                        fe_dl_in = sec_dl_ff;
                     end
                  end
               end
               CMD_TICK: begin
                  ok_in = 1'b1;
                  if (now_ff != DL_MAX) begin
                     now_in = now_ff + DL_W'(1);
                  end
               end
               default: begin
                  if (fire_ok) begin
                     ok_in                 = 1'b1;
                     rid_in                = best_ff.id;
                     rdl_in                = best_ff.deadline;
                     valid_in[best_idx_ff] = 1'b0;
                     count_in              = count_ff - CNT_W'(1);
                     fe_v_in               = sec_v_ff;
                     fe_dl_in              = sec_dl_ff;
                  end
               end
            endcase
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_id_in    = rid_ff;
               rsp_dl_in    = rdl_ff;
               rsp_sleep_in = (!fe_v_ff || diff[SLEEP_W-1]) ? {SLEEP_W{1'b1}} : diff;
               rsp_pend_in  = count_ff[PEND_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         now_ff       <= '0;
         next_id_ff   <= '0;
         cmp_act_ff   <= 1'b0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         sec_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         next_id_ff   <= next_id_in;
         cmp_act_ff   <= cmp_act_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         best_v_ff    <= best_v_in;
         sec_v_ff     <= sec_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      sec_dl_ff    <= sec_dl_in;
      ok_ff        <= ok_in;
      rid_ff       <= rid_in;
      rdl_ff       <= rdl_in;
      fe_v_ff      <= fe_v_in;
      fe_dl_ff     <= fe_dl_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_sleep_ff <= rsp_sleep_in;
      rsp_pend_ff  <= rsp_pend_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_timer_id       = rsp_id_ff;
   assign rsp_timer_deadline = rsp_dl_ff;
   assign rsp_sleep_ms       = rsp_sleep_ff;
   assign rsp_pending        = rsp_pend_ff;

endmodule

@@ design/odtt_checker.sv @@
module odtt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_ok,
   input logic [odtt_pkg::ID_W-1:0]           rsp_timer_id,
   input logic [odtt_pkg::DL_W-1:0]           rsp_timer_deadline,
   input logic signed [odtt_pkg::SLEEP_W-1:0] rsp_sleep_ms,
   input logic [odtt_pkg::PEND_W-1:0]         rsp_pending
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_timer_id) &&
         $stable(rsp_timer_deadline) && $stable(rsp_sleep_ms) && $stable(rsp_pending))
      else $error("stalled response changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while one is in progress");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared with no request in progress");

   a_sleep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sleep_ms[odtt_pkg::SLEEP_W-1] |-> &rsp_sleep_ms)
      else $error("sleep time negative other than -1");

endmodule

bind ordered_deadline_timer_table odtt_checker u_odtt_checker (.*);

@@ sim/tb_ordered_deadline_timer_table.sv @@
`timescale 1ns / 1ps

module tb_ordered_deadline_timer_table;
   import odtt_pkg::*;

   localparam int CAPACITY        = CAPACITY_DEF;
   localparam int OCCUPANCY       = CAPACITY + 4;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 600;

   typedef struct {
      logic               ok;
      logic [ID_W-1:0]    timer_id;
      logic [DL_W-1:0]    deadline;
      logic [SLEEP_W-1:0] sleep;
      logic [PEND_W-1:0]  pending;
   } timer_response_type;

   class timer_table_shadow;
      bit                 slot_used[CAPACITY];
      bit [ID_W-1:0]      slot_id[CAPACITY];
      bit [DL_W-1:0]      slot_deadline[CAPACITY];
      bit [DL_W-1:0]      now_ms;
      bit [ID_W-1:0]      next_id;
      int                 held;
      timer_response_type awaited[$];
      int                 mismatches;
      int                 checked;
      int                 adds_stored;
      int                 adds_refused;
      int                 cancels_hit;
      int                 fires_delivered;
      int                 peak_held;

      function int earliest();
         int best;
         best = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
                (slot_deadline[i] == slot_deadline[best] && slot_id[i] < slot_id[best])))
               best = i;
         end
         return best;
      endfunction

      function int find_slot(bit [ID_W-1:0] id, bit [DL_W-1:0] dl);
         for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_id[i] == id && slot_deadline[i] == dl)
               return i;
         return -1;
      endfunction

      function bit pick_live(output bit [ID_W-1:0] id, output bit [DL_W-1:0] dl);
         int live[$];
         int k;
         id = '0;
         dl = '0;
         for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i])
               live.push_back(i);
         if (live.size() == 0)
            return 1'b0;
         k = live[$urandom_range(live.size() - 1)];
         id = slot_id[k];
         dl = slot_deadline[k];
         return 1'b1;
      endfunction

      function void apply_request(cmd_type cmd, logic [DELAY_W-1:0] delay,
                                  logic [ID_W-1:0] cid, logic [DL_W-1:0] cdl);
         timer_response_type r;
         bit [DL_W:0]        sum;
         int                 slot;
         r.ok       = 1'b0;
         r.timer_id = '0;
         r.deadline = '0;
         case (cmd)
            CMD_ADD: begin
               sum        = now_ms + delay;
               r.deadline = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
               r.timer_id = next_id;
               next_id++;
               if (find_slot(r.timer_id, r.deadline) < 0) begin
                  for (int i = 0; i < CAPACITY && !r.ok; i++) begin
                     if (!slot_used[i]) begin
                        slot_used[i]     = 1'b1;
                        slot_id[i]       = r.timer_id;
                        slot_deadline[i] = r.deadline;
                        held++;
                        r.ok = 1'b1;
                     end
                  end
               end
               if (r.ok)
                  adds_stored++;
               else
                  adds_refused++;
            end
            CMD_CANCEL: begin
               slot = find_slot(cid, cdl);
               if (slot >= 0) begin
                  slot_used[slot] = 1'b0;
                  held--;
                  r.ok = 1'b1;
                  cancels_hit++;
               end
            end
            CMD_TICK: begin
               if (now_ms != DL_MAX)
                  now_ms++;
               r.ok = 1'b1;
            end
            default: begin
               slot = earliest();
               if (slot >= 0 && slot_deadline[slot] <= now_ms) begin
                  r.timer_id      = slot_id[slot];
                  r.deadline      = slot_deadline[slot];
                  slot_used[slot] = 1'b0;
                  held--;
                  r.ok = 1'b1;
                  fires_delivered++;
               end
            end
         endcase
         slot = earliest();
         if (slot < 0 || slot_deadline[slot] < now_ms)
            r.sleep = '1;
         else
            r.sleep = {1'b0, slot_deadline[slot] - now_ms};
         r.pending = PEND_W'(held);
         if (held > peak_held)
            peak_held = held;
         awaited.push_back(r);
      endfunction

      task report(string msg);
         if (mismatches < 100)
            $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_response(logic ok, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
                          logic [SLEEP_W-1:0] sleep, logic [PEND_W-1:0] pending);
         timer_response_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected response ok %0b id %0d deadline %0d", ok, id, dl));
            return;
         end
         want = awaited.pop_front();
         if (ok !== want.ok)
            report($sformatf("response %0d ok %0b, want %0b", checked, ok, want.ok));
         if (id !== want.timer_id)
            report($sformatf("response %0d timer_id %0d, want %0d", checked, id, want.timer_id));
         if (dl !== want.deadline)
            report($sformatf("response %0d deadline %0d, want %0d", checked, dl, want.deadline));
         if (sleep !== want.sleep)
            report($sformatf("response %0d sleep_ms %0d, want %0d", checked,
                             $signed(sleep), $signed(want.sleep)));
         if (pending !== want.pending)
            report($sformatf("response %0d pending %0d, want %0d", checked, pending,
                             want.pending));
         checked++;
      endtask

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   cmd_type                   req_command;
   logic [DELAY_W-1:0]        req_delay_ms;
   logic [ID_W-1:0]           req_cancel_id;
   logic [DL_W-1:0]           req_cancel_deadline;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_ok;
   logic [ID_W-1:0]           rsp_timer_id;
   logic [DL_W-1:0]           rsp_timer_deadline;
   logic signed [SLEEP_W-1:0] rsp_sleep_ms;
   logic [PEND_W-1:0]         rsp_pending;

   timer_table_shadow shadow = new();
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_left;
   int                offered;
   longint            cycles;

   ordered_deadline_timer_table #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_delay_ms        (req_delay_ms),
      .req_cancel_id       (req_cancel_id),
      .req_cancel_deadline (req_cancel_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ok              (rsp_ok),
      .rsp_timer_id        (rsp_timer_id),
      .rsp_timer_deadline  (rsp_timer_deadline),
      .rsp_sleep_ms        (rsp_sleep_ms),
      .rsp_pending         (rsp_pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_response(rsp_ok, rsp_timer_id, rsp_timer_deadline, rsp_sleep_ms,
                               rsp_pending);
   end

   // receiver: random stall, or a long hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic offer(cmd_type cmd, logic [DELAY_W-1:0] delay, logic [ID_W-1:0] cid,
                        logic [DL_W-1:0] cdl);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_delay_ms        <= delay;
      req_cancel_id       <= cid;
      req_cancel_deadline <= cdl;
      do @(posedge clock); while (req_stall);
      shadow.apply_request(cmd, delay, cid, cdl);
      offered++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (shadow.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic directed_items();
      logic [DELAY_W-1:0] delays[16] = '{0, 32'hFFFF_FFFF, 1, 1, 2, 0, 3, 4, 5, 6, 7, 8,
                                         9, 10, 11, 12};
      offer(CMD_FIRE, '0, '0, '0);
      offer(CMD_CANCEL, '1, '1, DL_MAX);
      foreach (delays[i])
         offer(CMD_ADD, delays[i], '1, '1);
      // table full: id used up, nothing stored
      offer(CMD_ADD, '1, '0, '0);
      offer(CMD_FIRE, '0, '0, '0);
      offer(CMD_CANCEL, '0, 32'd1, 48'hFFFF_FFFF);
      offer(CMD_CANCEL, '0, 32'd2, 48'd2);
      offer(CMD_TICK, '0, '0, '0);
      offer(CMD_FIRE, '0, '0, '0);
      // equal deadlines, lower id first
      offer(CMD_FIRE, '0, '0, '0);
      offer(CMD_FIRE, '0, '0, '0);
      offer(CMD_FIRE, '0, '0, '0);
   endtask

   task automatic random_item(bit fill_mood);
      cmd_type            cmd;
      logic [DELAY_W-1:0] delay;
      logic [ID_W-1:0]    cid;
      logic [DL_W-1:0]    cdl;
      bit [ID_W-1:0]      live_id;
      bit [DL_W-1:0]      live_dl;
      int                 r;
      r = $urandom_range(99);
      if (fill_mood)
         cmd = r < 55 ? CMD_ADD : r < 70 ? CMD_CANCEL : r < 85 ? CMD_TICK : CMD_FIRE;
      else
         cmd = r < 20 ? CMD_ADD : r < 40 ? CMD_CANCEL : r < 70 ? CMD_TICK : CMD_FIRE;
      delay = $urandom();
      if ($urandom_range(15) != 0)
         delay = $urandom_range(12);
      cid = $urandom();
      cdl = DL_W'({$urandom(), $urandom()});
      if (cmd == CMD_CANCEL) begin
         r = $urandom_range(99);
         if (r < 80 && shadow.pick_live(live_id, live_dl)) begin
            cid = live_id;
            cdl = live_dl;
            // near miss: one bit off in id or deadline
            if (r >= 65) begin
               if ($urandom_range(1))
                  cid = cid ^ (32'd1 << $urandom_range(ID_W - 1));
               else
                  cdl = cdl ^ (48'd1 << $urandom_range(DL_W - 1));
            end
         end
      end
      offer(cmd, delay, cid, cdl);
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = CMD_TICK;
      req_delay_ms        = '0;
      req_cancel_id       = '0;
      req_cancel_deadline = '0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      hold_left           = 0;
      offered             = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_items();
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 21 : ph == 1 ? 53 : 0;
         recv_idle_pct = ph == 0 ? 53 : ph == 1 ? 21 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == 150)
               hold_left = HOLD_OFF_CYCLES;
            if (ph == 1 && n == 300)
               drain();
            random_item(((n / 75) % 2) == 0);
         end
         drain();
      end

      repeat (4 * OCCUPANCY) @(posedge clock);

      $display("%0d requests: %0d timers stored, %0d adds refused, %0d cancels matched, %0d fired",
               offered, shadow.adds_stored, shadow.adds_refused, shadow.cancels_hit,
               shadow.fires_delivered);
      $display("%0d responses checked, peak occupancy %0d of %0d, clock at %0d ms",
               shadow.checked, shadow.peak_held, CAPACITY, shadow.now_ms);
      if (shadow.mismatches == 0 && shadow.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
